### sv/ps2mp_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ps2mp_pkg;

    localparam int BYTE_W   = 8;
    localparam int BTN_W    = 3;
    localparam int DELTA_W  = 9;
    localparam int POS_W    = 32;

    // Header bit positions
    localparam int HDR_VALID_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int HDR_XOVF_BIT  = 6;
    localparam int HDR_YOVF_BIT  = 7;

    // Place of the next byte within a packet
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } pos_t;

    // One assembled packet, handed from the framer to the output stage
    typedef struct packed {
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } packet_t;

endpackage

`default_nettype wire

### sv/ps2mp_in_stage.sv
// Input register of the decoder: holds one received byte for the framer.
// Depends on ps2mp_pkg.
`default_nettype none

module ps2mp_in_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ps2mp_pkg::BYTE_W-1:0] s_data_byte,
    input  wire logic                       advance,
    output logic                            byte_valid,
    output logic [ps2mp_pkg::BYTE_W-1:0]    byte_data
);
    import ps2mp_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg;

    // Take a new byte when empty or when the held byte moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

### sv/ps2mp_framer.sv
// Packet framer: tracks byte position, keeps header and X byte, flags complete packets.
// Depends on ps2mp_pkg.
`default_nettype none

module ps2mp_framer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         fire,
    input  wire logic [ps2mp_pkg::BYTE_W-1:0] byte_data,
    output logic                              pkt_valid,
    output ps2mp_pkg::packet_t                pkt
);
    import ps2mp_pkg::*;

    pos_t              pos_reg, pos_next;
    logic [BYTE_W-1:0] hdr_reg, hdr_next;
    logic [BYTE_W-1:0] xbyte_reg, xbyte_next;

    // Next position
    always_comb begin
        pos_next = pos_reg;
        if (fire) begin
            unique case (pos_reg)
                POS_HEADER: begin
                    // drop bytes without the always-one bit until a header shows up
                    pos_next = byte_data[HDR_VALID_BIT] ? POS_X : POS_HEADER;
                end
                POS_X: begin
                    pos_next = POS_Y;
                end
                POS_Y: begin
                    pos_next = POS_HEADER;
                end
                default: begin
                    pos_next = POS_HEADER;
                end
            endcase
        end
    end

    // Captures and packet output
    always_comb begin
        hdr_next   = hdr_reg;
        xbyte_next = xbyte_reg;
        pkt_valid  = 1'b0;
        unique case (pos_reg)
            POS_HEADER: begin
                if (fire && byte_data[HDR_VALID_BIT]) begin
                    hdr_next = byte_data;
                end
            end
            POS_X: begin
                if (fire) begin
                    xbyte_next = byte_data;
                end
            end
            POS_Y: begin
                pkt_valid = fire;
            end
            default: begin
                pkt_valid = 1'b0;
            end
        endcase
    end

    assign pkt.hdr    = hdr_reg;
    assign pkt.x_byte = xbyte_reg;
    assign pkt.y_byte = byte_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HEADER;
            hdr_reg   <= '0;
            xbyte_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            xbyte_reg <= xbyte_next;
        end
    end

endmodule

`default_nettype wire

### sv/ps2mp_out_stage.sv
// Output stage: decodes a packet, updates the position accumulators, holds the result.
// Depends on ps2mp_pkg.
`default_nettype none

module ps2mp_out_stage (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic                         pkt_valid,
    input  wire ps2mp_pkg::packet_t           pkt,
    output logic                              m_valid,
    output logic [ps2mp_pkg::BTN_W-1:0]       m_buttons,
    output logic signed [ps2mp_pkg::DELTA_W-1:0] m_delta_x,
    output logic signed [ps2mp_pkg::DELTA_W-1:0] m_delta_y,
    output logic                              m_overflow_x,
    output logic                              m_overflow_y,
    output logic signed [ps2mp_pkg::POS_W-1:0] m_pos_x,
    output logic signed [ps2mp_pkg::POS_W-1:0] m_pos_y
);
    import ps2mp_pkg::*;

    logic                      valid_reg, valid_next;
    logic [BTN_W-1:0]          buttons_reg;
    logic [DELTA_W-1:0]        dx_reg, dy_reg;
    logic                      ovf_x_reg, ovf_y_reg;
    logic [POS_W-1:0]          accum_x_reg, accum_x_next;
    logic [POS_W-1:0]          accum_y_reg, accum_y_next;
    logic [DELTA_W-1:0]        dx, dy;
    logic [POS_W-1:0]          dx_wide, dy_wide;
    logic                      load;

    // Header sign bit forms the ninth bit of each delta
    assign dx      = {pkt.hdr[HDR_XSIGN_BIT], pkt.x_byte};
    assign dy      = {pkt.hdr[HDR_YSIGN_BIT], pkt.y_byte};
    assign dx_wide = {{(POS_W-DELTA_W){dx[DELTA_W-1]}}, dx};
    assign dy_wide = {{(POS_W-DELTA_W){dy[DELTA_W-1]}}, dy};
    assign load    = advance && pkt_valid;

    always_comb begin
        valid_next   = advance ? pkt_valid : valid_reg;
        accum_x_next = accum_x_reg;
        accum_y_next = accum_y_reg;
        if (load) begin
            accum_x_next = accum_x_reg + dx_wide;
            accum_y_next = accum_y_reg - dy_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            accum_x_reg <= '0;
            accum_y_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            accum_x_reg <= accum_x_next;
            accum_y_reg <= accum_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buttons_reg <= pkt.hdr[BTN_W-1:0];
            dx_reg      <= dx;
            dy_reg      <= dy;
            ovf_x_reg   <= pkt.hdr[HDR_XOVF_BIT];
            ovf_y_reg   <= pkt.hdr[HDR_YOVF_BIT];
        end
    end

    assign m_valid      = valid_reg;
    assign m_buttons    = buttons_reg;
    assign m_delta_x    = $signed(dx_reg);
    assign m_delta_y    = $signed(dy_reg);
    assign m_overflow_x = ovf_x_reg;
    assign m_overflow_y = ovf_y_reg;
    assign m_pos_x      = $signed(accum_x_reg);
    assign m_pos_y      = $signed(accum_y_reg);

endmodule

`default_nettype wire

### sv/ps2_mouse_packet_decoder.sv
// PS/2 mouse three-byte packet decoder. Takes one mouse byte per transaction on the s_
// channel and gives one result transaction on the m_ channel for every complete packet
// (header, X byte, Y byte). A byte seen where a header is expected is dropped unless its
// bit 3 is set. Deltas are nine-bit signed values using header bits 4/5 as sign; X is
// added to and Y subtracted from 32-bit wrapping positions that reset to zero. Overflow
// bits are passed through as flags. One byte is accepted every cycle unless m_ready stalls
// the pipeline; a result reaches the result register through the input register after its
// Y byte is accepted, and m_ready low while a result waits stalls both registers together.
`default_nettype none

module ps2_mouse_packet_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ps2mp_pkg::BYTE_W-1:0]    s_data_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ps2mp_pkg::BTN_W-1:0]          m_buttons,
    output logic signed [ps2mp_pkg::DELTA_W-1:0] m_delta_x,
    output logic signed [ps2mp_pkg::DELTA_W-1:0] m_delta_y,
    output logic                                 m_overflow_x,
    output logic                                 m_overflow_y,
    output logic signed [ps2mp_pkg::POS_W-1:0]   m_pos_x,
    output logic signed [ps2mp_pkg::POS_W-1:0]   m_pos_y
);
    import ps2mp_pkg::*;

    logic              advance;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              fire;
    logic              pkt_valid;
    packet_t           pkt;

    // Pipeline moves whenever the result register is empty or being drained
    assign advance = !m_valid || m_ready;
    assign fire    = byte_valid && advance;

    ps2mp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .advance     (advance),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    ps2mp_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .byte_data (byte_data),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    ps2mp_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .pkt_valid    (pkt_valid),
        .pkt          (pkt),
        .m_valid      (m_valid),
        .m_buttons    (m_buttons),
        .m_delta_x    (m_delta_x),
        .m_delta_y    (m_delta_y),
        .m_overflow_x (m_overflow_x),
        .m_overflow_y (m_overflow_y),
        .m_pos_x      (m_pos_x),
        .m_pos_y      (m_pos_y)
    );

`ifndef NO_ASSERTIONS
    a_pkt_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && pkt_valid |=> m_valid)
        else $error("completed packet did not produce a result");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && pkt_valid) |=> $stable(m_pos_x) && $stable(m_pos_y))
        else $error("position changed without a completed packet");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register is empty");
`endif

endmodule

`default_nettype wire

### sim/ps2_mouse_packet_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ps2_mouse_packet_decoder: random byte streams with a
// packet-level pointer tracker predicting every report. Depends on ps2mp_pkg and the RTL.

module ps2_mouse_packet_decoder_test;
    import ps2mp_pkg::*;

    typedef struct {
        logic [BTN_W-1:0]          buttons;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      overflow_x;
        logic                      overflow_y;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
    } mouse_report_t;

    // Frames bytes into packets, tracks the pointer and holds the reports still owed.
    class pointer_tracker;
        pos_t                 place = POS_HEADER;
        logic [BYTE_W-1:0]    header = '0;
        logic [BYTE_W-1:0]    x_saved = '0;
        logic [POS_W-1:0]     sum_x = '0;
        logic [POS_W-1:0]     sum_y = '0;
        mouse_report_t        owed[$];
        int unsigned          errors = 0;
        int unsigned          accepted = 0;

        function void take_byte(logic [BYTE_W-1:0] value);
            mouse_report_t rep;
            logic [POS_W-1:0] dx;
            logic [POS_W-1:0] dy;
            accepted++;
            case (place)
                POS_X: begin
                    x_saved = value;
                    place = POS_Y;
                end
                POS_Y: begin
                    dx = {{24{header[HDR_XSIGN_BIT]}}, x_saved};
                    dy = {{24{header[HDR_YSIGN_BIT]}}, value};
                    sum_x = sum_x + dx;
                    sum_y = sum_y - dy;
                    rep.buttons    = header[BTN_W-1:0];
                    rep.delta_x    = dx[DELTA_W-1:0];
                    rep.delta_y    = dy[DELTA_W-1:0];
                    rep.overflow_x = header[HDR_XOVF_BIT];
                    rep.overflow_y = header[HDR_YOVF_BIT];
                    rep.pos_x      = sum_x;
                    rep.pos_y      = sum_y;
                    owed.push_back(rep);
                    place = POS_HEADER;
                end
                default: begin
                    // drop anything that is not a header while hunting for one
                    if (value[HDR_VALID_BIT]) begin
                        header = value;
                        place = POS_X;
                    end else begin
                        place = POS_HEADER;
                    end
                end
            endcase
        endfunction

        function void note_mismatch(string what, logic signed [31:0] want,
                                    logic signed [31:0] got);
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void match_report(mouse_report_t got);
            mouse_report_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: unexpected report, expected none, actual pos %0d/%0d",
                             $time, got.pos_x, got.pos_y);
                return;
            end
            want = owed.pop_front();
            if (got.buttons !== want.buttons)
                note_mismatch("buttons", want.buttons, got.buttons);
            if (got.delta_x !== want.delta_x)
                note_mismatch("delta_x", want.delta_x, got.delta_x);
            if (got.delta_y !== want.delta_y)
                note_mismatch("delta_y", want.delta_y, got.delta_y);
            if (got.overflow_x !== want.overflow_x)
                note_mismatch("overflow_x", want.overflow_x, got.overflow_x);
            if (got.overflow_y !== want.overflow_y)
                note_mismatch("overflow_y", want.overflow_y, got.overflow_y);
            if (got.pos_x !== want.pos_x)
                note_mismatch("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
                note_mismatch("pos_y", want.pos_y, got.pos_y);
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [BYTE_W-1:0]         s_data_byte;
    logic                      m_valid;
    logic                      m_ready;
    logic [BTN_W-1:0]          m_buttons;
    logic signed [DELTA_W-1:0] m_delta_x;
    logic signed [DELTA_W-1:0] m_delta_y;
    logic                      m_overflow_x;
    logic                      m_overflow_y;
    logic signed [POS_W-1:0]   m_pos_x;
    logic signed [POS_W-1:0]   m_pos_y;

    pointer_tracker tracker;
    int             burst_left = 0;
    bit             held_off = 1'b0;

    // Invalid headers, zero motion, both sign extremes, overflow flags, resync.
    logic [BYTE_W-1:0] directed_seq [24] = '{
        8'h00, 8'hF7,
        8'h08, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF,
        8'h38, 8'h00, 8'h00,
        8'h0F, 8'hFF, 8'hFF,
        8'hC8, 8'h80, 8'h7F,
        8'h01,
        8'h19, 8'h00, 8'h08,
        8'h2A, 8'h01, 8'hFE
    };

    ps2_mouse_packet_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_buttons    (m_buttons),
        .m_delta_x    (m_delta_x),
        .m_delta_y    (m_delta_y),
        .m_overflow_x (m_overflow_x),
        .m_overflow_y (m_overflow_y),
        .m_pos_x      (m_pos_x),
        .m_pos_y      (m_pos_y)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offer one byte, inserting a random gap at burst boundaries; return once accepted.
    task automatic offer_byte(input logic [BYTE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic offer_packet();
        logic [BYTE_W-1:0] hdr;
        hdr = 8'($urandom);
        hdr[HDR_VALID_BIT] = 1'b1;
        offer_byte(hdr);
        offer_byte(8'($urandom));
        offer_byte(8'($urandom));
    endtask

    initial begin
        int packet_bytes;
        tracker     = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_seq[i])
            offer_byte(directed_seq[i]);

        // Mostly well-formed packets; stray bytes knock the framing off now and then.
        packet_bytes = 0;
        while (packet_bytes < 1200) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_byte(8'($urandom));
            end else begin
                offer_packet();
                packet_bytes += 3;
            end
        end
        s_valid <= 1'b0;

        // let the monitor note the last accepted byte before draining
        @(posedge aclk);
        while (tracker.owed.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0 && tracker.owed.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: random stall modes in stretches, plus one long hold-off.
    initial begin
        int mode;
        int stretch;
        int cyc;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        cyc = 0;
        forever begin
            if (!held_off && tracker.accepted >= 150) begin
                // hold off long enough for the block to back up into the sender
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                held_off = 1'b1;
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 150);
            repeat (stretch) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 5) != 0;
                endcase
                cyc++;
                @(posedge aclk);
            end
        end
    end

    // Sample both channels at the edge that completes each transaction.
    always @(posedge aclk) begin
        mouse_report_t seen;
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_byte(s_data_byte);
            if (m_valid && m_ready) begin
                seen.buttons    = m_buttons;
                seen.delta_x    = m_delta_x;
                seen.delta_y    = m_delta_y;
                seen.overflow_x = m_overflow_x;
                seen.overflow_y = m_overflow_y;
                seen.pos_x      = m_pos_x;
                seen.pos_y      = m_pos_y;
                tracker.match_report(seen);
            end
        end
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
